@@ design/ihs_pkg.sv @@
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types and constants for the image header size sniffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihs_pkg;

  localparam logic [1:0] FMT_JPEG = 2'd0;
  localparam logic [1:0] FMT_PCX  = 2'd1;
  localparam logic [1:0] FMT_GIF  = 2'd2;
  localparam logic [1:0] FMT_PNG  = 2'd3;

  localparam logic [7:0]  JPEG_MARK     = 8'hFF;
  localparam logic [7:0]  JPEG_SOF0     = 8'hC0;
  localparam logic [7:0]  JPEG_SOF2     = 8'hC2;
  localparam logic [31:0] PNG_IHDR      = 32'h49484452;
  localparam logic [3:0]  PCX_BASE      = 4'd8;
  localparam logic [3:0]  GIF_BASE      = 4'd6;
  localparam logic [3:0]  POS_MAX       = 4'd15;
  localparam logic [2:0]  JPEG_SKIP_END = 3'd2;
  localparam logic [2:0]  JPEG_CAP_END  = 3'd3;
  localparam logic [2:0]  PNG_CAP_END   = 3'd7;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SAW_FF  = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_CAPTURE = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic        found;
  } ihs_result_t;

endpackage

@@ design/ihs_parser.sv @@
// ----------------------------------------------------------------------------
// ihs_parser
// Per-file scan state; updates once for every accepted byte beat and forms
// the size result for the final byte of a file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihs_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output ihs_pkg::ihs_result_t result
);

  logic [1:0]       format_mode;
  logic [3:0]       byte_position;
  ihs_pkg::phase_t  scan_phase;
  logic [2:0]       field_byte_count;
  logic [23:0]      recent_bytes;
  logic [63:0]      capture_shift;
  logic [31:0]      held_width;
  logic [31:0]      held_height;
  logic             have_size;

  logic [3:0]       pos_upd;
  ihs_pkg::phase_t  phase_upd;
  logic [2:0]       count_upd;
  logic [23:0]      recent_upd;
  logic [63:0]      shift_upd;
  logic [31:0]      width_upd;
  logic [31:0]      height_upd;
  logic             have_upd;
  logic [31:0]      window;
  logic [3:0]       base;
  logic             truncated;

  always_comb begin
    pos_upd    = (byte_position == ihs_pkg::POS_MAX) ? byte_position : byte_position + 4'd1;
    phase_upd  = scan_phase;
    count_upd  = field_byte_count;
    recent_upd = recent_bytes;
    shift_upd  = capture_shift;
    width_upd  = held_width;
    height_upd = held_height;
    have_upd   = have_size;
    window     = {recent_bytes, data_byte};
    base       = (format_mode == ihs_pkg::FMT_PCX) ? ihs_pkg::PCX_BASE : ihs_pkg::GIF_BASE;
    case (format_mode)
      ihs_pkg::FMT_JPEG: begin
        case (scan_phase)
          ihs_pkg::PH_IDLE: begin
            if (data_byte == ihs_pkg::JPEG_MARK) begin
              phase_upd = ihs_pkg::PH_SAW_FF;
            end
          end
          ihs_pkg::PH_SAW_FF: begin
            if (data_byte == ihs_pkg::JPEG_SOF0 || data_byte == ihs_pkg::JPEG_SOF2) begin
              phase_upd = ihs_pkg::PH_SKIP;
              count_upd = 3'd0;
            end else if (data_byte != ihs_pkg::JPEG_MARK) begin
              phase_upd = ihs_pkg::PH_IDLE;
            end
          end
          ihs_pkg::PH_SKIP: begin
            if (field_byte_count >= ihs_pkg::JPEG_SKIP_END) begin
              phase_upd = ihs_pkg::PH_CAPTURE;
              count_upd = 3'd0;
              shift_upd = 64'd0;
            end else begin
              count_upd = field_byte_count + 3'd1;
            end
          end
          ihs_pkg::PH_CAPTURE: begin
            shift_upd = {32'd0, capture_shift[23:0], data_byte};
            if (field_byte_count >= ihs_pkg::JPEG_CAP_END) begin
              height_upd = {16'd0, shift_upd[31:16]};
              width_upd  = {16'd0, shift_upd[15:0]};
              have_upd   = 1'b1;
              phase_upd  = ihs_pkg::PH_IDLE;
              count_upd  = 3'd0;
            end else begin
              count_upd = field_byte_count + 3'd1;
            end
          end
          default: begin
            phase_upd = ihs_pkg::PH_IDLE;
          end
        endcase
      end
      ihs_pkg::FMT_PCX, ihs_pkg::FMT_GIF: begin
        if (byte_position == base) begin
          width_upd = {24'd0, data_byte};
        end else if (byte_position == base + 4'd1) begin
          width_upd = held_width | {16'd0, data_byte, 8'd0};
        end else if (byte_position == base + 4'd2) begin
          height_upd = {24'd0, data_byte};
        end else if (byte_position == base + 4'd3) begin
          height_upd = held_height | {16'd0, data_byte, 8'd0};
          have_upd   = 1'b1;
        end
      end
      default: begin
        if (scan_phase == ihs_pkg::PH_IDLE) begin
          if (window == ihs_pkg::PNG_IHDR) begin
            phase_upd = ihs_pkg::PH_CAPTURE;
            count_upd = 3'd0;
            shift_upd = 64'd0;
          end
        end else if (scan_phase == ihs_pkg::PH_CAPTURE) begin
          shift_upd = {capture_shift[55:0], data_byte};
          if (field_byte_count >= ihs_pkg::PNG_CAP_END) begin
            width_upd  = shift_upd[63:32];
            height_upd = shift_upd[31:0];
            have_upd   = 1'b1;
            phase_upd  = ihs_pkg::PH_DONE;
            count_upd  = 3'd0;
          end else begin
            count_upd = field_byte_count + 3'd1;
          end
        end
        recent_upd = window[23:0];
      end
    endcase
    truncated = (format_mode == ihs_pkg::FMT_JPEG) &&
                (phase_upd == ihs_pkg::PH_SKIP || phase_upd == ihs_pkg::PH_CAPTURE);
    result.found  = have_upd && !truncated;
    result.width  = result.found ? width_upd : 32'd0;
    result.height = result.found ? height_upd : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= ihs_pkg::FMT_JPEG;
    end else if (cfg_wr_en) begin
      format_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en || (step && last_byte)) begin
      byte_position    <= 4'd0;
      scan_phase       <= ihs_pkg::PH_IDLE;
      field_byte_count <= 3'd0;
      recent_bytes     <= 24'd0;
      capture_shift    <= 64'd0;
      held_width       <= 32'd0;
      held_height      <= 32'd0;
      have_size        <= 1'b0;
    end else if (step) begin
      byte_position    <= pos_upd;
      scan_phase       <= phase_upd;
      field_byte_count <= count_upd;
      recent_bytes     <= recent_upd;
      capture_shift    <= shift_upd;
      held_width       <= width_upd;
      held_height      <= height_upd;
      have_size        <= have_upd;
    end
  end

endmodule

@@ design/image_header_size_sniffer.sv @@
// ----------------------------------------------------------------------------
// image_header_size_sniffer
// Streams the bytes of one image file and reports its width and height on
// the final byte, using the JPEG, PCX, GIF or PNG header rule.
//
//   Channel  Signals                                   Direction
//   input    in_valid, in_ready, data_byte, last_byte   in  (ready out)
//   output   out_valid, out_ready, image_width,         out (ready in)
//            image_height, size_found
//   config   cfg_wr_en, cfg_wr_data (format_mode)       in
//
// One byte beat is taken each cycle unless stalled; results appear the cycle
// after the final byte. The single output register sets the pace: input
// stalls only while a result is held and out_ready is low. Synchronous reset
// clears the scan and selects JPEG; a format write also restarts the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_header_size_sniffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] image_width,
  output logic [31:0] image_height,
  output logic        size_found
);

  ihs_pkg::ihs_result_t result;
  logic                 in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  ihs_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step       (in_fire),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      image_width  <= result.width;
      image_height <= result.height;
      size_found   <= result.found;
    end
  end

endmodule

@@ test/tb_image_header_size_sniffer.sv @@
// ----------------------------------------------------------------------------
// tb_image_header_size_sniffer
// Feeds whole image files through the sniffer one byte beat at a time and
// checks every reported size against a scan model kept inside the bench.
// Short directed files cover each format and the end-of-file corner cases,
// then randomly built files, mostly well formed, run with random gaps on
// both channels and with format writes between files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_image_header_size_sniffer;
  import ihs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic        size_found;

  image_header_size_sniffer uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .image_width  (image_width),
    .image_height (image_height),
    .size_found   (size_found)
  );

  // Scan state mirrored from the block.
  logic [1:0]  fmt_sel;
  logic [3:0]  pos_cnt;
  phase_t      phase_m;
  logic [2:0]  field_cnt;
  logic [23:0] tail3;
  logic [63:0] shift_acc;
  logic [31:0] width_acc;
  logic [31:0] height_acc;
  logic        size_seen;

  ihs_result_t expected_sizes[$];
  logic [7:0]  file_bytes[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          out_hold;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  ihs_result_t want_r;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    out_ready = 1'b0;
    out_hold = 0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sizes.size() == 0) begin
        if (errors < 10)
          $display("Unexpected result: w=%0h h=%0h found=%0b",
                   image_width, image_height, size_found);
        errors++;
      end else begin
        want_r = expected_sizes.pop_front();
        if (image_width !== want_r.width || image_height !== want_r.height ||
            size_found !== want_r.found) begin
          if (errors < 10)
            $display("Mismatch: expected w=%0h h=%0h found=%0b, got w=%0h h=%0h found=%0b",
                     want_r.width, want_r.height, want_r.found,
                     image_width, image_height, size_found);
          errors++;
        end
      end
    end
  end

  function automatic void clear_scan();
    pos_cnt = '0;
    phase_m = PH_IDLE;
    field_cnt = '0;
    tail3 = '0;
    shift_acc = '0;
    width_acc = '0;
    height_acc = '0;
    size_seen = 1'b0;
  endfunction

  function automatic void take_fixed(input logic [3:0] at, input logic [7:0] b,
                                     input logic [3:0] base);
    if (at == base) begin
      width_acc = {24'h0, b};
    end else if (at == base + 4'd1) begin
      width_acc = width_acc | {16'h0, b, 8'h0};
    end else if (at == base + 4'd2) begin
      height_acc = {24'h0, b};
    end else if (at == base + 4'd3) begin
      height_acc = height_acc | {16'h0, b, 8'h0};
      size_seen = 1'b1;
    end
  endfunction

  task automatic sniff_byte(input logic [7:0] b, input logic fin);
    logic [3:0]  at;
    logic [31:0] window;
    logic        hit;
    ihs_result_t r;
    at = pos_cnt;
    if (pos_cnt < POS_MAX) pos_cnt = pos_cnt + 4'd1;
    case (fmt_sel)
      FMT_JPEG: begin
        case (phase_m)
          PH_IDLE: begin
            if (b == JPEG_MARK) phase_m = PH_SAW_FF;
          end
          PH_SAW_FF: begin
            if (b == JPEG_SOF0 || b == JPEG_SOF2) begin
              phase_m = PH_SKIP;
              field_cnt = '0;
            end else if (b != JPEG_MARK) begin
              phase_m = PH_IDLE;
            end
          end
          PH_SKIP: begin
            if (field_cnt >= JPEG_SKIP_END) begin
              phase_m = PH_CAPTURE;
              field_cnt = '0;
              shift_acc = '0;
            end else begin
              field_cnt = field_cnt + 3'd1;
            end
          end
          PH_CAPTURE: begin
            shift_acc = {32'h0, shift_acc[23:0], b};
            if (field_cnt >= JPEG_CAP_END) begin
              height_acc = {16'h0, shift_acc[31:16]};
              width_acc = {16'h0, shift_acc[15:0]};
              size_seen = 1'b1;
              phase_m = PH_IDLE;
              field_cnt = '0;
            end else begin
              field_cnt = field_cnt + 3'd1;
            end
          end
          default: phase_m = PH_IDLE;
        endcase
      end
      FMT_PCX: take_fixed(at, b, PCX_BASE);
      FMT_GIF: take_fixed(at, b, GIF_BASE);
      default: begin
        window = {tail3, b};
        if (phase_m == PH_IDLE) begin
          if (window == PNG_IHDR) begin
            phase_m = PH_CAPTURE;
            field_cnt = '0;
            shift_acc = '0;
          end
        end else if (phase_m == PH_CAPTURE) begin
          shift_acc = {shift_acc[55:0], b};
          if (field_cnt >= PNG_CAP_END) begin
            width_acc = shift_acc[63:32];
            height_acc = shift_acc[31:0];
            size_seen = 1'b1;
            phase_m = PH_DONE;
            field_cnt = '0;
          end else begin
            field_cnt = field_cnt + 3'd1;
          end
        end
        tail3 = window[23:0];
      end
    endcase
    if (fin) begin
      hit = size_seen;
      if (fmt_sel == FMT_JPEG && (phase_m == PH_SKIP || phase_m == PH_CAPTURE)) hit = 1'b0;
      r.width = hit ? width_acc : 32'h0;
      r.height = hit ? height_acc : 32'h0;
      r.found = hit;
      expected_sizes.push_back(r);
      clear_scan();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    sniff_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_file(input bit terminate);
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], terminate && (i == file_bytes.size() - 1));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input logic [1:0] f);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fmt_sel = f;
    clear_scan();
  endtask

  task automatic push_jpeg_noise(input int n);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: file_bytes.push_back(JPEG_MARK);
        1: file_bytes.push_back(JPEG_SOF0);
        2: file_bytes.push_back(JPEG_SOF2);
        default: file_bytes.push_back(rand_byte());
      endcase
    end
  endtask

  task automatic push_png_noise(input int n);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: file_bytes.push_back(PNG_IHDR[31:24]);
        1: file_bytes.push_back(PNG_IHDR[23:16]);
        2: file_bytes.push_back(PNG_IHDR[15:8]);
        3: file_bytes.push_back(PNG_IHDR[7:0]);
        default: file_bytes.push_back(rand_byte());
      endcase
    end
  endtask

  task automatic push_ihdr_chunk();
    for (int k = 3; k >= 0; k--) file_bytes.push_back(PNG_IHDR[8*k +: 8]);
    repeat (8) file_bytes.push_back(rand_byte());
  endtask

  task automatic maybe_truncate();
    int keep;
    if ($urandom_range(0, 5) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endtask

  task automatic build_jpeg_file();
    int segs;
    file_bytes.delete();
    segs = $urandom_range(0, 2);
    repeat (segs) begin
      push_jpeg_noise($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) file_bytes.push_back(JPEG_MARK);
      file_bytes.push_back(JPEG_MARK);
      file_bytes.push_back($urandom_range(0, 1) ? JPEG_SOF0 : JPEG_SOF2);
      repeat (7) file_bytes.push_back(rand_byte());
    end
    push_jpeg_noise($urandom_range(0, 3));
    if (file_bytes.size() == 0) file_bytes.push_back(rand_byte());
    maybe_truncate();
  endtask

  task automatic build_fixed_file(input logic [3:0] base);
    int len;
    file_bytes.delete();
    if ($urandom_range(0, 4) == 0) len = $urandom_range(1, base + 4);
    else len = base + 4 + $urandom_range(0, 5);
    repeat (len) file_bytes.push_back(rand_byte());
  endtask

  task automatic build_png_file();
    file_bytes.delete();
    push_png_noise($urandom_range(0, 5));
    if ($urandom_range(0, 5) != 0) begin
      push_ihdr_chunk();
      push_png_noise($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) push_ihdr_chunk();
    end
    if (file_bytes.size() == 0) file_bytes.push_back(rand_byte());
    maybe_truncate();
  endtask

  task automatic test_jpeg_after_reset();
    file_bytes = '{JPEG_MARK, JPEG_SOF2, 8'h00, 8'h11, 8'h08,
                   8'hFF, 8'hFF, 8'h00, 8'h01};
    send_file(1'b1);
  endtask

  task automatic test_jpeg_edge_cases();
    file_bytes = '{JPEG_MARK};
    send_file(1'b1);
    file_bytes = '{JPEG_MARK, JPEG_SOF0, 8'h00};
    send_file(1'b1);
  endtask

  task automatic test_pcx_header();
    drain_results();
    write_format(FMT_PCX);
    file_bytes = '{8'h0A, 8'h05, 8'h01, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h34, 8'h12, 8'hFF, 8'hFF};
    send_file(1'b1);
  endtask

  task automatic test_gif_header();
    drain_results();
    write_format(FMT_GIF);
    file_bytes = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61,
                   8'h80, 8'h02, 8'hE0, 8'h01};
    send_file(1'b1);
  endtask

  task automatic test_png_header();
    drain_results();
    write_format(FMT_PNG);
    file_bytes = '{PNG_IHDR[31:24], PNG_IHDR[23:16], PNG_IHDR[15:8], PNG_IHDR[7:0],
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
    send_file(1'b1);
  endtask

  task automatic test_format_write_restart();
    drain_results();
    write_format(FMT_GIF);
    file_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
    send_file(1'b0);
    drain_results();
    write_format(FMT_GIF);
    file_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h00, 8'h02, 8'h00};
    send_file(1'b1);
  endtask

  task automatic test_random_files();
    logic [1:0] nf;
    bit         restart;
    while (bytes_sent < 450) begin
      steady = ($urandom_range(0, 4) == 0);
      nf = 2'($urandom_range(0, 3));
      if (nf != fmt_sel || $urandom_range(0, 9) == 0) begin
        drain_results();
        write_format(nf);
      end
      case (fmt_sel)
        FMT_JPEG: build_jpeg_file();
        FMT_PCX:  build_fixed_file(PCX_BASE);
        FMT_GIF:  build_fixed_file(GIF_BASE);
        default:  build_png_file();
      endcase
      restart = ($urandom_range(0, 9) == 0);
      send_file(!restart);
      if (restart) begin
        drain_results();
        write_format(2'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    fmt_sel = FMT_JPEG;
    clear_scan();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_jpeg_after_reset();
    test_jpeg_edge_cases();
    test_pcx_header();
    test_gif_header();
    test_png_header();
    test_format_write_restart();
    test_random_files();

    drain_results();
    if (errors == 0 && expected_sizes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
